>>> hdl/cirm_pkg.sv
package cirm_pkg;

    localparam int STAGES_DEF     = 7;
    localparam int ENTRIES_DEF    = 32;
    localparam int VALUE_BITS_DEF = 40;

    localparam int FIELD_BITS = 40;
    localparam int S_DATA_BITS = 208;
    localparam int M_DATA_BITS = 80;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_MAP   = 2'd2,
        FUNC_RANGE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

endpackage

>>> hdl/chained_interval_remap_min.sv
// Remap chain with running minimum. All entries sit in one synchronous memory
// of STAGES*ENTRIES words, scanned one entry per cycle; a stage stops at its
// first matching entry, and the stages of a single map are scanned one after
// another through the single read port of the table memory. A range request
// repeats that scan for each value of the range. Entry writes and clears go
// through ST_FIN to the output register and return a result as well. A new
// request is taken once the previous result has moved into the output
// register; the result waits there until m_tready.
module chained_interval_remap_min
    import cirm_pkg::*;
#(
    parameter int STAGES     = STAGES_DEF,
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // stage[2:0] slot[7:3] dest_start[47:8] src_start[87:48] span[127:88]
    // value[167:128] count[207:168]
    input  logic [S_DATA_BITS-1:0]  s_tdata,
    // func[1:0]
    input  logic [1:0]              s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // location[39:0] lowest[79:40]
    output logic [M_DATA_BITS-1:0]  m_tdata
);

    localparam int VB    = VALUE_BITS;
    localparam int TOTAL = STAGES * ENTRIES;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int SW    = $clog2(STAGES + 1);
    localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW    = (VB + 1 > FIELD_BITS) ? VB + 1 : FIELD_BITS;
    localparam logic [CW-1:0] SPAN_C = CW'(1) << VB;

    // request fields
    logic [2:0]            in_stage;
    logic [4:0]            in_slot;
    logic [FIELD_BITS-1:0] in_dest, in_src, in_span, in_value, in_count;
    func_t                 in_func;
    assign in_stage = s_tdata[2:0];
    assign in_slot  = s_tdata[7:3];
    assign in_dest  = s_tdata[47:8];
    assign in_src   = s_tdata[87:48];
    assign in_span  = s_tdata[127:88];
    assign in_value = s_tdata[167:128];
    assign in_count = s_tdata[207:168];
    assign in_func  = func_t'(s_tuser);

    // table memory: {dest, src, length}
    logic [3*VB-1:0] mem [TOTAL];
    logic [3*VB-1:0] rd_reg;
    logic [TOTAL-1:0] valid_reg;

    state_t          state_reg, state_next;
    logic [SW-1:0]   st_reg, st_next;
    logic [EW:0]     e_reg, e_next;
    logic            chk_reg, chk_next;
    logic            chk_ok_reg;
    logic [SW-1:0]   chk_st_reg, chk_st_next;
    logic [VB-1:0]   x_reg, x_next;
    logic [VB-1:0]   cur_reg, cur_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic            single_reg, single_next;
    logic [VB-1:0]   low_reg, low_next;
    logic            none_reg, none_next;
    logic            mv_reg;
    logic [M_DATA_BITS-1:0] md_reg;

    logic            accept, issue, hit, done, better;
    logic [AW-1:0]   rd_addr, wr_addr;
    logic            wr_en;
    logic [VB-1:0]   ent_d, ent_s, ent_l;
    logic [VB:0]     ent_end;
    logic [CW-1:0]   cnt_ext;

    assign accept  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    assign rd_addr = AW'(st_reg * ENTRIES) + AW'(e_reg[EW-1:0]);
    assign wr_addr = AW'(in_stage * ENTRIES) + AW'(in_slot);
    assign wr_en   = accept && in_func == FUNC_WRITE
                     && 32'(in_stage) < STAGES && 32'(in_slot) < ENTRIES;

    assign ent_d   = rd_reg[3*VB-1:2*VB];
    assign ent_s   = rd_reg[2*VB-1:VB];
    assign ent_l   = rd_reg[VB-1:0];
    assign ent_end = {1'b0, ent_s} + {1'b0, ent_l};
    assign hit     = chk_reg && chk_ok_reg && x_reg >= ent_s
                     && {1'b0, x_reg} < ent_end;
    assign issue   = (state_reg == ST_SCAN) && 32'(st_reg) < STAGES && !hit;
    assign done    = (state_reg == ST_SCAN) && !chk_reg && 32'(st_reg) >= STAGES;
    assign better  = none_reg || x_reg < low_reg;
    assign cnt_ext = CW'(in_count);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {VB'(in_dest), VB'(in_src), VB'(in_span)};
        end
        if (issue) begin
            rd_reg     <= mem[rd_addr];
            chk_ok_reg <= valid_reg[rd_addr];
        end
    end

    always_comb begin
        state_next  = state_reg;
        st_next     = st_reg;
        e_next      = e_reg;
        chk_next    = 1'b0;
        chk_st_next = chk_st_reg;
        x_next      = x_reg;
        cur_next    = cur_reg;
        rem_next    = rem_reg;
        single_next = single_reg;
        low_next    = low_reg;
        none_next   = none_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    single_next = (in_func == FUNC_MAP);
                    st_next     = '0;
                    e_next      = '0;
                    x_next      = VB'(in_value);
                    cur_next    = VB'(in_value);
                    rem_next    = (in_func == FUNC_MAP) ? CW'(1)
                                  : ((cnt_ext > SPAN_C) ? SPAN_C : cnt_ext);
                    if (in_func == FUNC_CLEAR) begin
                        none_next = 1'b1;
                        low_next  = '1;
                    end
                    if ((in_func == FUNC_MAP)
                        || (in_func == FUNC_RANGE && in_count != '0)) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    // first match ends this stage; no new read is issued on a match
                    x_next  = x_reg - ent_s + ent_d;
                    st_next = chk_st_reg + SW'(1);
                    e_next  = '0;
                end else if (issue) begin
                    chk_next    = 1'b1;
                    chk_st_next = st_reg;
                    if (32'(e_reg) == ENTRIES - 1) begin
                        e_next  = '0;
                        st_next = st_reg + SW'(1);
                    end else begin
                        e_next = e_reg + (EW+1)'(1);
                    end
                end else if (done) begin
                    if (better) begin
                        low_next  = x_reg;
                        none_next = 1'b0;
                    end
                    if (rem_reg > CW'(1)) begin
                        rem_next = rem_reg - CW'(1);
                        cur_next = cur_reg + VB'(1);
                        x_next   = cur_reg + VB'(1);
                        st_next  = '0;
                        e_next   = '0;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (!mv_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            chk_reg   <= 1'b0;
            none_reg  <= 1'b1;
            low_reg   <= '1;
            valid_reg <= '0;
            mv_reg    <= 1'b0;
            st_reg    <= '0;
            e_reg     <= '0;
        end else begin
            state_reg <= state_next;
            chk_reg   <= chk_next;
            none_reg  <= none_next;
            low_reg   <= low_next;
            st_reg    <= st_next;
            e_reg     <= e_next;
            if (accept && in_func == FUNC_CLEAR) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (state_reg == ST_FIN && (!mv_reg || m_tready)) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        chk_st_reg <= chk_st_next;
        x_reg      <= x_next;
        cur_reg    <= cur_next;
        rem_reg    <= rem_next;
        single_reg <= single_next;
        if (state_reg == ST_FIN && (!mv_reg || m_tready)) begin
            md_reg[39:0]  <= single_reg ? FIELD_BITS'(x_reg) : '0;
            md_reg[79:40] <= none_reg ? '1 : FIELD_BITS'(low_reg);
        end
    end

    a_chk_only_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        chk_reg |-> state_reg == ST_SCAN)
        else $error("entry check pending outside scan");

    a_stage_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(st_reg) <= STAGES)
        else $error("stage counter past chain end");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("request taken while busy");

    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !issue && !hit)
        else $error("scan finished with work in flight");

endmodule

>>> tb/chained_interval_remap_min_chk.sv
module chained_interval_remap_min_chk
    import cirm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_DATA_BITS-1:0] s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_DATA_BITS-1:0] m_tdata,
    output int                     fail_count,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSTAGE = STAGES_DEF;
    localparam int NSLOT  = ENTRIES_DEF;
    localparam int NENT   = NSTAGE * NSLOT;

    typedef struct {
        logic [39:0] location;
        logic [39:0] lowest;
    } remap_result_t;

    logic [39:0]   tbl_dest [NENT];
    logic [39:0]   tbl_src  [NENT];
    logic [39:0]   tbl_span [NENT];
    logic          tbl_valid[NENT];
    logic [39:0]   min_seen;
    remap_result_t result_q[$];

    // walk the chain; source intervals are compared in 41 bits so they never wrap
    function automatic logic [39:0] chain_remap(logic [39:0] x);
        int          idx;
        logic [40:0] top;
        for (int st = 0; st < NSTAGE; st++) begin
            for (int e = 0; e < NSLOT; e++) begin
                idx = st * NSLOT + e;
                top = {1'b0, tbl_src[idx]} + {1'b0, tbl_span[idx]};
                if (tbl_valid[idx] && x >= tbl_src[idx] && {1'b0, x} < top) begin
                    x = x - tbl_src[idx] + tbl_dest[idx];
                    break;
                end
            end
        end
        return x;
    endfunction

    always @(posedge aclk) begin
        func_t         fn;
        logic [2:0]    st;
        logic [4:0]    sl;
        logic [39:0]   v;
        logic [39:0]   cnt;
        logic [39:0]   mapped;
        logic          bad;
        remap_result_t exp_r;
        if (!aresetn) begin
            for (int i = 0; i < NENT; i++) tbl_valid[i] = 1'b0;
            min_seen = '1;
            result_q.delete();
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                fn  = func_t'(s_tuser);
                st  = s_tdata[2:0];
                sl  = s_tdata[7:3];
                v   = s_tdata[167:128];
                cnt = s_tdata[207:168];
                exp_r.location = '0;
                case (fn)
                    FUNC_WRITE: begin
                        if (st < NSTAGE) begin
                            tbl_dest[st*NSLOT+sl]  = s_tdata[47:8];
                            tbl_src[st*NSLOT+sl]   = s_tdata[87:48];
                            tbl_span[st*NSLOT+sl]  = s_tdata[127:88];
                            tbl_valid[st*NSLOT+sl] = 1'b1;
                        end
                    end
                    FUNC_CLEAR: begin
                        for (int i = 0; i < NENT; i++) tbl_valid[i] = 1'b0;
                        min_seen = '1;
                    end
                    FUNC_MAP: begin
                        exp_r.location = chain_remap(v);
                        if (exp_r.location < min_seen) min_seen = exp_r.location;
                    end
                    FUNC_RANGE: begin
                        // stimulus keeps range counts small, so map value by value
                        for (longint i = 0; i < cnt; i++) begin
                            mapped = chain_remap(v + 40'(i));
                            if (mapped < min_seen) min_seen = mapped;
                        end
                    end
                    default: ;
                endcase
                exp_r.lowest = min_seen;
                result_q.insert(result_q.size(), exp_r);
            end
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected result: location %h lowest %h",
                           m_tdata[39:0], m_tdata[79:40]);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = result_q.pop_front();
                    bad   = 1'b0;
                    if (m_tdata[39:0] !== exp_r.location) begin
                        $error("location: expected %h, got %h", exp_r.location,
                               m_tdata[39:0]);
                        bad = 1'b1;
                    end
                    if (m_tdata[79:40] !== exp_r.lowest) begin
                        $error("lowest: expected %h, got %h", exp_r.lowest,
                               m_tdata[79:40]);
                        bad = 1'b1;
                    end
                    if (bad) fail_count <= fail_count + 1;
                end
            end
        end
        outstanding <= result_q.size();
    end
endmodule

>>> tb/chained_interval_remap_min_tb.sv
module chained_interval_remap_min_tb;
    import cirm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [39:0] TOP40 = '1;
    localparam int IDLE_LIMIT = 40000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata = '0;
    logic [1:0]             s_tuser = FUNC_WRITE;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;
    int                     fail_count;
    int                     outstanding;
    logic                   no_idle = 1'b0;
    int                     stall_left = 0;
    int                     idle_cycles = 0;
    int                     n_write = 0, n_clear = 0, n_map = 0, n_range = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    chained_interval_remap_min u_top (.*);

    chained_interval_remap_min_chk u_chk (.*);

    // result side backpressure, drawn per result
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (m_tvalid && m_tready && !no_idle) stall_left <= $urandom_range(0, 8);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("chained_interval_remap_min verification failed");
            $finish;
        end
    end

    // values cluster in a low and a high window so entries actually hit
    function automatic logic [39:0] pick_val();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 40'($urandom_range(0, 600));
        if (r < 75) return TOP40 - 40'($urandom_range(0, 600));
        return 40'({$urandom, $urandom});
    endfunction

    task automatic send_request(func_t fn, logic [2:0] st, logic [4:0] sl,
                                logic [39:0] dst, logic [39:0] src, logic [39:0] len,
                                logic [39:0] v, logic [39:0] cnt);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= fn;
        s_tdata  <= {cnt, v, len, src, dst, sl, st};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        case (fn)
            FUNC_WRITE: n_write++;
            FUNC_CLEAR: n_clear++;
            FUNC_MAP:   n_map++;
            default:    n_range++;
        endcase
    endtask

    task automatic wait_drained();
        while (outstanding != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        int          r;
        logic [39:0] junk;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty tables, zero count, slot priority, wrap, ignored write
        send_request(FUNC_MAP, 0, 0, 0, 0, 0, 40'd0, TOP40);
        send_request(FUNC_RANGE, 0, 0, 0, 0, 0, 40'd5, 40'd0);
        send_request(FUNC_WRITE, 0, 31, 40'd100, 40'd10, 40'd10, 0, 0);
        send_request(FUNC_WRITE, 0, 0, 40'd0, 40'd12, 40'd3, 0, 0);
        send_request(FUNC_MAP, 0, 0, 0, 0, 0, 40'd13, 0);
        send_request(FUNC_MAP, 0, 0, 0, 0, 0, 40'd15, 0);
        send_request(FUNC_MAP, 0, 0, 0, 0, 0, 40'd20, 0);
        send_request(FUNC_WRITE, 6, 5, TOP40, 40'd0, 40'd2, 0, 0);
        send_request(FUNC_MAP, 0, 0, 0, 0, 0, 40'd1, 0);
        send_request(FUNC_WRITE, 7, 31, TOP40, TOP40, TOP40, TOP40, TOP40);
        send_request(FUNC_WRITE, 1, 3, 40'd0, TOP40 - 40'd3, TOP40, 0, 0);
        send_request(FUNC_MAP, 0, 0, 0, 0, 0, TOP40, 0);
        send_request(FUNC_RANGE, 0, 0, 0, 0, 0, TOP40 - 40'd1, 40'd4);
        send_request(FUNC_RANGE, 0, 0, 0, 0, 0, 40'd9, 40'd6);
        send_request(FUNC_WRITE, 2, 1, 40'd7, 40'd50, 40'd0, 0, 0);
        send_request(FUNC_MAP, 0, 0, 0, 0, 0, 40'd50, 0);
        send_request(FUNC_WRITE, 3, 0, TOP40, TOP40, TOP40, 0, 0);
        send_request(FUNC_MAP, 0, 0, 0, 0, 0, TOP40 - 40'd2, 0);
        send_request(FUNC_CLEAR, 0, 0, TOP40, TOP40, TOP40, TOP40, TOP40);
        send_request(FUNC_MAP, 0, 0, 0, 0, 0, 40'd7, 0);
        send_request(FUNC_RANGE, 0, 0, 0, 0, 0, TOP40, 40'd1);

        for (int i = 0; i < 1130; i++) begin
            if (i % 150 == 0) no_idle <= ($urandom_range(0, 3) == 0);
            if (i == 600) begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            r    = $urandom_range(0, 99);
            junk = 40'({$urandom, $urandom});
            if (r < 32)
                send_request(FUNC_WRITE, 3'($urandom_range(0, 7)),
                             ($urandom_range(0, 2) == 0) ? 5'($urandom) :
                                                           5'($urandom_range(0, 5)),
                             pick_val(), pick_val(),
                             ($urandom_range(0, 4) == 0) ? pick_val() :
                                                           40'($urandom_range(0, 300)),
                             junk, 40'({$urandom, $urandom}));
            else if (r < 35)
                send_request(FUNC_CLEAR, 3'($urandom), 5'($urandom), junk, junk,
                             junk, junk, 40'({$urandom, $urandom}));
            else if (r < 88)
                send_request(FUNC_MAP, 3'($urandom), 5'($urandom), junk, junk, junk,
                             pick_val(), 40'({$urandom, $urandom}));
            else
                send_request(FUNC_RANGE, 3'($urandom), 5'($urandom), junk, junk, junk,
                             pick_val(), 40'($urandom_range(0, 6)));
        end
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (300) @(posedge aclk);

        $display("covered %0d entry writes, %0d clears, %0d single maps, %0d range maps",
                 n_write, n_clear, n_map, n_range);
        $display("with random gaps and stalls on both channels and a full drain midway");
        if (fail_count == 0 && outstanding == 0) begin
            $display("chained_interval_remap_min verification clean");
        end else begin
            $display("chained_interval_remap_min verification failed");
        end
        $finish;
    end
endmodule

>>> chained_interval_remap_min.f
hdl/cirm_pkg.sv
hdl/chained_interval_remap_min.sv
tb/chained_interval_remap_min_chk.sv
tb/chained_interval_remap_min_tb.sv
